@@ design/focal_point_phase_macros.svh @@
// assertion macros shared by the focal point phase rtl
`ifndef FOCAL_POINT_PHASE_MACROS_SVH
`define FOCAL_POINT_PHASE_MACROS_SVH

// property holds at every clock edge outside reset
`define FPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define FPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/fpp_pkg.sv @@
// types and constants for the focal point phase block
`default_nettype none
package fpp_pkg;

  typedef enum logic [2:0] {
    REG_FOCUS_X     = 3'd0,
    REG_FOCUS_Y     = 3'd1,
    REG_FOCUS_Z     = 3'd2,
    REG_WAVE_LENGTH = 3'd3,
    REG_DUTY_LEVEL  = 3'd4
  } cfg_reg_e;

  localparam int          WaveBits     = 16;
  localparam int          FracBits     = 16;
  localparam int          DutyBits     = 8;
  localparam int          PhaseBits    = 8;
  localparam logic [15:0] WaveLenReset = 16'd2176;
  localparam logic [7:0]  PhaseMax     = 8'd255;

endpackage
`default_nettype wire

@@ design/focal_point_phase.sv @@
// focal point phase: drive word from transducer position and focal point
// one item accepted per cycle while the output is not stalled, passing through
// the square root stages (one root bit each) and divider stages (one bit each)
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// async active-low reset clears valid bits and loads the register reset values
`default_nettype none
`include "focal_point_phase_macros.svh"
module focal_point_phase #(
  parameter int COORD_BITS = 22
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              stall_o,
  input  wire logic signed [COORD_BITS-1:0] pos_x_i,
  input  wire logic signed [COORD_BITS-1:0] pos_y_i,
  input  wire logic signed [COORD_BITS-1:0] pos_z_i,
  output logic                              valid_o,
  input  wire logic                         stall_i,
  output logic [15:0]                       drive_word_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [2:0]                   cfg_index_i,
  input  wire logic [(COORD_BITS > 16 ? COORD_BITS : 16)-1:0] cfg_data_i
);

  localparam int CB = COORD_BITS;
  localparam int RW = CB + 1;

  logic signed [CB-1:0] focus_x_q, focus_y_q, focus_z_q;
  logic [15:0]          wave_q;
  logic [7:0]           duty_q;
  logic                 adv;

  assign cfg_ready_o = 1'b1;
  assign adv         = !(valid_o && stall_i);
  assign stall_o     = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focus_x_q <= '0;
      focus_y_q <= '0;
      focus_z_q <= '0;
      wave_q    <= fpp_pkg::WaveLenReset;
      duty_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (fpp_pkg::cfg_reg_e'(cfg_index_i))
        fpp_pkg::REG_FOCUS_X:     focus_x_q <= cfg_data_i[CB-1:0];
        fpp_pkg::REG_FOCUS_Y:     focus_y_q <= cfg_data_i[CB-1:0];
        fpp_pkg::REG_FOCUS_Z:     focus_z_q <= cfg_data_i[CB-1:0];
        fpp_pkg::REG_WAVE_LENGTH: wave_q    <= cfg_data_i[15:0];
        fpp_pkg::REG_DUTY_LEVEL:  duty_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  function automatic logic [CB-1:0] abs_diff(logic [CB-1:0] a, logic [CB-1:0] b);
    logic [CB:0] d;
    d = {a[CB-1], a} - {b[CB-1], b};
    return d[CB] ? CB'(-d) : d[CB-1:0];
  endfunction

  // stage 1: absolute differences
  logic          v1_q;
  logic [CB-1:0] dx_q, dy_q, dz_q;
  // stage 2: squares
  logic            v2_q;
  logic [2*CB-1:0] sx_q, sy_q, sz_q;
  // stage 3: sum of squares
  logic            v3_q;
  logic [2*RW-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q  <= abs_diff(pos_x_i, focus_x_q);
      dy_q  <= abs_diff(pos_y_i, focus_y_q);
      dz_q  <= abs_diff(pos_z_i, focus_z_q);
      sx_q  <= dx_q * dx_q;
      sy_q  <= dy_q * dy_q;
      sz_q  <= dz_q * dz_q;
      sum_q <= (2*RW)'(sx_q) + (2*RW)'(sy_q) + (2*RW)'(sz_q);
    end
  end

  logic          root_v;
  logic [RW-1:0] root;

  fpp_sqrt #(.RW(RW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v3_q),
    .rad_i   (sum_q),
    .valid_o (root_v),
    .root_o  (root)
  );

  logic        frac_v;
  logic [15:0] frac;

  fpp_div #(.RW(RW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (root_v),
    .root_i  (root),
    .wave_i  (wave_q),
    .valid_o (frac_v),
    .frac_o  (frac)
  );

  // round(255 * (1 - f)), zero wavelength means zero fraction
  logic [16:0] inv;
  logic [24:0] scaled;
  logic [7:0]  phase;

  always_comb begin
    inv    = 17'h10000 - {1'b0, frac};
    scaled = 25'(inv) * 25'd255 + 25'd32768;
    phase  = (wave_q == '0) ? fpp_pkg::PhaseMax : scaled[23:16];
  end

  logic        out_v_q;
  logic [15:0] word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= frac_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      word_q <= {duty_q, phase};
    end
  end

  assign valid_o      = out_v_q;
  assign drive_word_o = word_q;

  `FPP_ASSERT(a_stall_needs_out, !stall_o || valid_o, "stall without a waiting result")
  `FPP_ASSERT_NEXT(a_enter, valid_i && !stall_o, v1_q, "accepted item lost at stage one")
  `FPP_ASSERT_NEXT(a_freeze, stall_o, $stable(v3_q) && $stable(word_q), "pipeline moved in stall")

endmodule
`default_nettype wire

@@ design/fpp_sqrt.sv @@
// pipelined integer square root, one root bit per stage
`default_nettype none
module fpp_sqrt #(
  parameter int RW = 23
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            adv_i,
  input  wire logic            valid_i,
  input  wire logic [2*RW-1:0] rad_i,
  output logic                 valid_o,
  output logic [RW-1:0]        root_o
);

  logic            vq [RW+1];
  logic [2*RW-1:0] nq [RW+1];
  logic [RW-1:0]   rq [RW+1];
  logic [RW-1:0]   qq [RW+1];

  assign vq[0] = valid_i;
  assign nq[0] = rad_i;
  assign rq[0] = '0;
  assign qq[0] = '0;

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RW+1:0] cur, trial, diff;
    logic          ge;

    always_comb begin
      cur   = {rq[s], nq[s][2*RW-1 -: 2]};
      trial = {qq[s], 2'b01};
      diff  = cur - trial;
      ge    = cur >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq[s+1] <= 1'b0;
      end else if (adv_i) begin
        vq[s+1] <= vq[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        nq[s+1] <= nq[s] << 2;
        rq[s+1] <= ge ? diff[RW-1:0] : cur[RW-1:0];
        qq[s+1] <= {qq[s][RW-2:0], ge};
      end
    end
  end

  assign valid_o = vq[RW];
  assign root_o  = qq[RW];

endmodule
`default_nettype wire

@@ design/fpp_div.sv @@
// pipelined restoring divider, keeps the fraction bits of root / wavelength
`default_nettype none
module fpp_div #(
  parameter int RW = 23
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          valid_i,
  input  wire logic [RW-1:0] root_i,
  input  wire logic [15:0]   wave_i,
  output logic               valid_o,
  output logic [15:0]        frac_o
);

  localparam int DW = RW + fpp_pkg::FracBits;

  logic          vq [DW+1];
  logic [DW-1:0] dq [DW+1];
  logic [15:0]   rq [DW+1];
  logic [15:0]   qq [DW+1];

  assign vq[0] = valid_i;
  assign dq[0] = {root_i, 16'h0000};
  assign rq[0] = '0;
  assign qq[0] = '0;

  for (genvar s = 0; s < DW; s++) begin : g_stage
    logic [16:0] cur, diff;
    logic        ge;

    always_comb begin
      cur  = {rq[s], dq[s][DW-1]};
      ge   = cur >= {1'b0, wave_i};
      diff = cur - {1'b0, wave_i};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq[s+1] <= 1'b0;
      end else if (adv_i) begin
        vq[s+1] <= vq[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dq[s+1] <= dq[s] << 1;
        rq[s+1] <= ge ? diff[15:0] : cur[15:0];
        qq[s+1] <= {qq[s][14:0], ge};
      end
    end
  end

  assign valid_o = vq[DW];
  assign frac_o  = qq[DW];

endmodule
`default_nettype wire

@@ sim/focal_point_phase_tb.sv @@
// testbench for focal_point_phase: directed table, then random items against a predictor
`timescale 1ns / 1ps
module focal_point_phase_tb;

  localparam int CoordBits = 22;
  localparam int CfgBits   = 22;
  localparam int Latency   = 2 * CoordBits + 22;
  localparam int RandItems = 210;
  localparam int NumPhases = 6;
  localparam int CycleLimit = 1000000;
  localparam logic [2:0] RegUnused = 3'd7;
  localparam logic [2:0] RegPastLast = 3'd5;
  localparam logic signed [CoordBits-1:0] CoordMax = 22'sh1FFFFF;
  localparam logic signed [CoordBits-1:0] CoordMin = 22'sh200000;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct {
    coord_t      x;
    coord_t      y;
    coord_t      z;
    bit          typed;
    logic [15:0] word;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 valid_i;
  logic                 stall_o;
  coord_t               pos_x_i, pos_y_i, pos_z_i;
  logic                 valid_o;
  logic                 stall_i;
  logic [15:0]          drive_word_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [2:0]           cfg_index_i;
  logic [CfgBits-1:0]   cfg_data_i;

  // predictor copy of the registers
  coord_t      focus_x, focus_y, focus_z;
  logic [15:0] wave_len;
  logic [7:0]  duty;

  logic [15:0] drive_q[$];
  int          fails;
  int          cycles;
  int          tx_idle_pct, rx_idle_pct;
  int          rx_hold_left;
  row_t        dir_rows[$];

  focal_point_phase u_top (
    .clk_i, .rst_ni, .valid_i, .stall_o, .pos_x_i, .pos_y_i, .pos_z_i,
    .valid_o, .stall_i, .drive_word_o, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  function automatic logic [15:0] drive_word_of(coord_t px, coord_t py, coord_t pz);
    longint            dx, dy, dz;
    longint unsigned   sum, radius, c, frac;
    logic [7:0]        phase;
    dx = longint'(px) - longint'(focus_x);
    dy = longint'(py) - longint'(focus_y);
    dz = longint'(pz) - longint'(focus_z);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dz < 0) dz = -dz;
    sum    = dx * dx + dy * dy + dz * dz;
    radius = 0;
    for (int b = 31; b >= 0; b--) begin
      c = radius | (64'd1 << b);
      if (c * c <= sum) radius = c;
    end
    frac = 0;
    if (wave_len != 0) frac = ((radius % wave_len) << fpp_pkg::FracBits) / wave_len;
    phase = 8'((255 * (65536 - frac) + 32768) >> 16);
    return {duty, phase};
  endfunction

  task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
    $display("mismatch %s: expected %h got %h at cycle %0d", what, want, got, cycles);
    fails++;
  endtask

  // leaves valid high, the caller drops it after the last write
  task automatic write_reg(logic [2:0] idx, logic [CfgBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      fpp_pkg::REG_FOCUS_X:     focus_x  = data[CoordBits-1:0];
      fpp_pkg::REG_FOCUS_Y:     focus_y  = data[CoordBits-1:0];
      fpp_pkg::REG_FOCUS_Z:     focus_z  = data[CoordBits-1:0];
      fpp_pkg::REG_WAVE_LENGTH: wave_len = data[fpp_pkg::WaveBits-1:0];
      fpp_pkg::REG_DUTY_LEVEL:  duty     = data[fpp_pkg::DutyBits-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    wait (drive_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic send_item(coord_t x, coord_t y, coord_t z, bit typed, logic [15:0] word);
    int gap;
    valid_i <= 1'b1;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    do @(posedge clk_i); while (stall_o);
    drive_q.push_back(typed ? word : drive_word_of(x, y, z));
    if ($urandom_range(99) < tx_idle_pct) begin
      valid_i <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  // receiver stall, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      stall_i <= 1'b1;
    end else begin
      stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (drive_q.size() == 0) begin
        report_mismatch("unexpected item", 16'h0, drive_word_o);
      end else begin
        if (drive_word_o !== drive_q[0])
          report_mismatch("drive_word", drive_q[0], drive_word_o);
        void'(drive_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    coord_t fx, fy, fz, x, y, z;
    logic [15:0] wl;
    fails = 0;
    cycles = 0;
    rx_hold_left = 0;
    tx_idle_pct = 13;
    rx_idle_pct = 59;
    rst_ni = 1'b0;
    valid_i = 1'b0;
    stall_i = 1'b0;
    pos_x_i = '0;
    pos_y_i = '0;
    pos_z_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = fpp_pkg::REG_FOCUS_X;
    cfg_data_i = '0;
    focus_x = '0;
    focus_y = '0;
    focus_z = '0;
    wave_len = fpp_pkg::WaveLenReset;
    duty = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: focus at origin, wavelength 2176, duty zero
    dir_rows = '{
      '{22'sd0, 22'sd0, 22'sd0, 1'b1, 16'h00FF},
      '{22'sd2176, 22'sd0, 22'sd0, 1'b1, 16'h00FF},
      '{22'sd1088, 22'sd0, 22'sd0, 1'b1, 16'h0080},
      '{22'sd0, -22'sd4352, 22'sd0, 1'b1, 16'h00FF},
      '{22'sd1, 22'sd0, 22'sd0, 1'b0, 16'h0},
      '{22'sd2175, 22'sd0, 22'sd0, 1'b0, 16'h0},
      '{22'sd2172, 22'sd0, 22'sd0, 1'b0, 16'h0},
      '{CoordMax, CoordMax, CoordMax, 1'b0, 16'h0},
      '{CoordMin, CoordMin, CoordMin, 1'b0, 16'h0},
      '{CoordMax, CoordMin, CoordMax, 1'b0, 16'h0},
      '{CoordMin, CoordMax, 22'sd0, 1'b0, 16'h0},
      '{-22'sd1, -22'sd1, -22'sd1, 1'b0, 16'h0},
      '{22'sd300, 22'sd400, 22'sd0, 1'b0, 16'h0},
      '{22'sd12345, -22'sd6789, 22'sd1000, 1'b0, 16'h0},
      '{22'sh155555, 22'sh2AAAAA, 22'sh0F0F0F, 1'b0, 16'h0}
    };
    foreach (dir_rows[i])
      send_item(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].typed,
                dir_rows[i].word);
    valid_i <= 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      tx_idle_pct = (p < 2) ? 13 : (p < 4) ? 59 : 0;
      rx_idle_pct = (p < 2) ? 59 : (p < 4) ? 13 : 0;
      case (p)
        0: begin fx = CoordMax; fy = CoordMin; fz = CoordMax; wl = 16'd1; end
        1: begin fx = CoordMin; fy = CoordMax; fz = CoordMin; wl = 16'hFFFF; end
        2: begin fx = '0; fy = '0; fz = '0; wl = 16'd0; end
        default: begin
          fx = rand_coord(); fy = rand_coord(); fz = rand_coord();
          wl = 16'($urandom_range(1, 65535));
        end
      endcase
      write_reg(fpp_pkg::REG_FOCUS_X, CfgBits'(fx));
      write_reg(fpp_pkg::REG_FOCUS_Y, CfgBits'(fy));
      write_reg(fpp_pkg::REG_FOCUS_Z, CfgBits'(fz));
      // upper data bits are junk the register must drop
      write_reg(fpp_pkg::REG_WAVE_LENGTH, {6'($urandom), wl});
      write_reg(fpp_pkg::REG_DUTY_LEVEL,
                {14'($urandom), (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom)});
      write_reg(RegUnused, CfgBits'($urandom));
      write_reg(RegPastLast, CfgBits'($urandom));
      cfg_valid_i <= 1'b0;

      for (int n = 0; n < RandItems; n++) begin
        if (p == 1 && n == 20) rx_hold_left = 300;
        if (p == 3 && n == 100) begin
          valid_i <= 1'b0;
          wait (drive_q.size() == 0);
          @(posedge clk_i);
        end
        if ($urandom_range(3) == 0) begin
          x = rand_coord(); y = rand_coord(); z = rand_coord();
        end else begin
          // near the focus, where the phase wraps often
          x = focus_x + coord_t'($urandom_range(0, 16383)) - 22'sd8192;
          y = focus_y + coord_t'($urandom_range(0, 16383)) - 22'sd8192;
          z = focus_z + coord_t'($urandom_range(0, 16383)) - 22'sd8192;
        end
        send_item(x, y, z, 1'b0, 16'h0);
      end
      valid_i <= 1'b0;
    end

    wait_drained();
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
